// File: sv/sxfr_pkg.sv
// shared types and constants for the stx/etx xor frame receiver
`default_nettype none

package sxfr_pkg;

    // framing bytes
    localparam logic [7:0] STX_BYTE = 8'h02;
    localparam logic [7:0] ETX_BYTE = 8'h03;

    // payload size limit in four-byte words
    localparam int MAX_WORDS_DEF = 16;

    // register reset values
    localparam logic [4:0]  PAYLOAD_WORDS_RST = 5'd1;
    localparam logic [31:0] TIMEOUT_TICKS_RST = 32'd1000;

    // register indexes on the config port
    localparam logic REG_PAYLOAD_WORDS = 1'b0;
    localparam logic REG_TIMEOUT_TICKS = 1'b1;

    // input item kind
    typedef enum logic {
        FUNC_BYTE = 1'b0,
        FUNC_TICK = 1'b1
    } func_t;

    // result item kind
    typedef enum logic [1:0] {
        KIND_NONE   = 2'd0,
        KIND_BYTE   = 2'd1,
        KIND_STATUS = 2'd2
    } kind_t;

    // frame outcome
    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_BAD_START = 3'd1,
        ST_TIMEOUT   = 3'd2,
        ST_BAD_END   = 3'd3,
        ST_CHECKSUM  = 3'd4
    } status_t;

endpackage

`default_nettype wire

// File: sv/stx_etx_xor_frame_receiver_unit.sv
// stx/etx framed byte receiver with xor checksum and inter-byte timeout
`default_nettype none

// channel   | ports           | contents (low bits first)
// ----------+-----------------+------------------------------------------------
// input     | s_tvalid/tready | s_tdata: rx_byte[7:0]; s_tuser: func
// result    | m_tvalid/tready | m_tdata: payload_byte[7:0], byte_index[13:8],
//           |                 |   frame_status[16:14], zero fill; m_tuser: kind
// config    | apb             | 0x0 payload_words, 0x4 timeout_ticks
//
// one item per cycle unless stalled: every item is decoded and produces one result in the
// same cycle it is taken, the result sits in the output register next cycle.
// the output register stalls the input only while it holds a result that the
// sink has not taken. synchronous active-low reset clears the frame state and
// loads register defaults (1 word, 1000 ticks).

module stx_etx_xor_frame_receiver_unit #(
    parameter int MAX_WORDS = sxfr_pkg::MAX_WORDS_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // input item stream
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // rx_byte
    input  wire logic        s_tuser,   // func
    // result item stream
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [23:0]      m_tdata,   // payload_byte, byte_index, frame_status
    output logic [1:0]       m_tuser,   // kind
    // apb config port
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    import sxfr_pkg::*;

    // word count and byte count widths
    localparam int WW = $clog2(MAX_WORDS + 1);
    localparam int FW = WW + 2;
    localparam int CW = $clog2(MAX_WORDS * 4 + 1);

    typedef enum logic [1:0] {
        PH_WAIT,
        PH_PAYLOAD,
        PH_CHECK,
        PH_END
    } phase_t;

    // config registers
    logic [4:0]  payload_words_reg;
    logic [31:0] timeout_ticks_reg;

    // frame state
    phase_t        phase_reg, phase_next;
    logic [CW-1:0] bytes_seen_reg, bytes_seen_next;
    logic [7:0]    running_xor_reg, running_xor_next;
    logic [7:0]    received_checksum_reg, received_checksum_next;
    logic [31:0]   idle_ticks_reg, idle_ticks_next;

    // output register
    logic        m_valid_reg;
    kind_t       kind_reg, kind_next;
    logic [7:0]  payload_byte_reg, payload_byte_next;
    logic [5:0]  byte_index_reg, byte_index_next;
    status_t     status_reg, status_next;

    logic          in_accept;
    logic          cfg_write;
    logic [WW-1:0] words_eff;
    logic [FW-1:0] frame_bytes;
    logic [CW-1:0] seen_inc;
    logic [31:0]   idle_inc;

    assign s_tready  = !m_valid_reg || m_tready;
    assign in_accept = s_tvalid && s_tready;
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    // register readback
    always_comb begin
        case (paddr[2])
            REG_PAYLOAD_WORDS: prdata = {27'd0, payload_words_reg};
            REG_TIMEOUT_TICKS: prdata = timeout_ticks_reg;
            default:           prdata = 32'd0;
        endcase
    end

    // config writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            payload_words_reg <= PAYLOAD_WORDS_RST;
            timeout_ticks_reg <= TIMEOUT_TICKS_RST;
        end else if (cfg_write) begin
            case (paddr[2])
                REG_PAYLOAD_WORDS: payload_words_reg <= pwdata[4:0];
                REG_TIMEOUT_TICKS: timeout_ticks_reg <= pwdata;
                default: ;
            endcase
        end
    end

    // payload length, clamped to the word limit
    always_comb begin
        if ({27'd0, payload_words_reg} > 32'(MAX_WORDS)) begin
            words_eff = WW'(MAX_WORDS);
        end else begin
            words_eff = WW'(payload_words_reg);
        end
        frame_bytes = {words_eff, 2'b00};
        seen_inc    = bytes_seen_reg + CW'(1);
        idle_inc    = (idle_ticks_reg == 32'hFFFF_FFFF) ? idle_ticks_reg
                                                        : idle_ticks_reg + 32'd1;
    end

    // per-item decode
    always_comb begin
        phase_next             = phase_reg;
        bytes_seen_next        = bytes_seen_reg;
        running_xor_next       = running_xor_reg;
        received_checksum_next = received_checksum_reg;
        idle_ticks_next        = idle_ticks_reg;
        kind_next              = KIND_NONE;
        payload_byte_next      = 8'd0;
        byte_index_next        = 6'd0;
        status_next            = ST_OK;

        if (s_tuser == FUNC_TICK) begin
            // timeout tick, only counts inside a frame
            if (phase_reg != PH_WAIT) begin
                idle_ticks_next = idle_inc;
                if (idle_inc >= timeout_ticks_reg) begin
                    phase_next             = PH_WAIT;
                    bytes_seen_next        = '0;
                    running_xor_next       = 8'd0;
                    received_checksum_next = 8'd0;
                    idle_ticks_next        = 32'd0;
                    kind_next              = KIND_STATUS;
                    status_next            = ST_TIMEOUT;
                end
            end
        end else begin
            idle_ticks_next = 32'd0;
            case (phase_reg)
                PH_WAIT: begin
                    if (s_tdata != STX_BYTE) begin
                        kind_next   = KIND_STATUS;
                        status_next = ST_BAD_START;
                    end else begin
                        bytes_seen_next        = '0;
                        running_xor_next       = 8'd0;
                        received_checksum_next = 8'd0;
                        phase_next = (frame_bytes == '0) ? PH_CHECK : PH_PAYLOAD;
                    end
                end
                PH_PAYLOAD: begin
                    running_xor_next  = running_xor_reg ^ s_tdata;
                    bytes_seen_next   = seen_inc;
                    if ((FW + CW)'(seen_inc) >= (FW + CW)'(frame_bytes)) begin
                        phase_next = PH_CHECK;
                    end
                    kind_next         = KIND_BYTE;
                    payload_byte_next = s_tdata;
                    byte_index_next   = 6'(bytes_seen_reg);
                end
                PH_CHECK: begin
                    received_checksum_next = s_tdata;
                    phase_next             = PH_END;
                end
                default: begin
                    // etx is checked before the checksum
                    if (s_tdata != ETX_BYTE) begin
                        status_next = ST_BAD_END;
                    end else if (running_xor_reg != received_checksum_reg) begin
                        status_next = ST_CHECKSUM;
                    end else begin
                        status_next = ST_OK;
                    end
                    kind_next              = KIND_STATUS;
                    phase_next             = PH_WAIT;
                    bytes_seen_next        = '0;
                    running_xor_next       = 8'd0;
                    received_checksum_next = 8'd0;
                end
            endcase
        end
    end

    // frame state and output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg             <= PH_WAIT;
            bytes_seen_reg        <= '0;
            running_xor_reg       <= 8'd0;
            received_checksum_reg <= 8'd0;
            idle_ticks_reg        <= 32'd0;
            m_valid_reg           <= 1'b0;
        end else begin
            if (in_accept) begin
                phase_reg             <= phase_next;
                bytes_seen_reg        <= bytes_seen_next;
                running_xor_reg       <= running_xor_next;
                received_checksum_reg <= received_checksum_next;
                idle_ticks_reg        <= idle_ticks_next;
                m_valid_reg           <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // result payload, loaded with each accepted item
    always_ff @(posedge aclk) begin
        if (in_accept) begin
            kind_reg         <= kind_next;
            payload_byte_reg <= payload_byte_next;
            byte_index_reg   <= byte_index_next;
            status_reg       <= status_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = kind_reg;
    assign m_tdata  = {7'd0, status_reg, byte_index_reg, payload_byte_reg};

endmodule

`default_nettype wire
